// ----- sv/svpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// Space vector PWM duty package
// Shared widths, fixed-point constants, pipeline layout and the sector type.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    // Field widths.
    localparam int DATA_W      = 16;
    localparam int DUTY_W      = 16;
    localparam int SECTOR_W    = 3;

    // Quotient of the normalizing division: Q2.16 magnitude, up to 2.0.
    localparam int QUO_W       = 18;
    localparam int LOW_W       = QUO_W - DATA_W;
    localparam int NORM_W      = QUO_W + 1;

    // Width of the sector terms and duty sums (covers +-2^21).
    localparam int T_W         = 22;

    // Fixed-point constants, Q16.
    localparam int Q_ONE           = 65536;
    localparam int Q_SAT           = 131072;
    localparam int K_INV_SQRT3     = 37838;
    localparam int K_TWO_INV_SQRT3 = 75675;
    localparam int ROUND_HALF      = 32768;
    localparam int Q_FRAC          = 16;
    localparam int DUTY_MAX        = 65535;

    // Pipeline layout: an input stage, the division stages, one saturation
    // stage, then the duty stages.
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = QUO_W / DIV_BITS;
    localparam int NORM_STAGE  = DIV_STEPS + 1;
    localparam int DUTY_STAGES = 4;
    localparam int PIPE_DEPTH  = NORM_STAGE + 1 + DUTY_STAGES;

    typedef enum logic [SECTOR_W-1:0] {
        SECTOR_1 = 3'd0,
        SECTOR_2 = 3'd1,
        SECTOR_3 = 3'd2,
        SECTOR_4 = 3'd3,
        SECTOR_5 = 3'd4,
        SECTOR_6 = 3'd5
    } t_sector;

endpackage

`default_nettype wire

// ----- sv/svpwm_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Space vector PWM pipeline control
// Carries the valid bit of each stage and derives the per-stage load enables.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_pipe_ctrl
    import svpwm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [PIPE_DEPTH-1:0]      o_en
);

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] n_valid;
    logic [PIPE_DEPTH-1:0] w_en;

    // A stage may load when the output is taken or some stage at or after it
    // holds a bubble. Each enable is its own reduction, so no long chain forms.
    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            w_en[k] = i_m_tready
                    | ~&(r_valid | ((PIPE_DEPTH'(1) << k) - PIPE_DEPTH'(1)));
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_en[0]) begin
            n_valid[0] = i_s_tvalid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en       = w_en;
    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_valid[PIPE_DEPTH-1];

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready although the output stage is empty");

    a_ready_when_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input not ready although the output is being taken");

    a_stall_holds_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid && !i_m_tready) |-> (w_en == '0))
        else $error("full pipeline advanced while the output was stalled");

endmodule

`default_nettype wire

// ----- sv/svpwm_norm_div.sv -----
// ----------------------------------------------------------------------------
// Space vector PWM normalizing divider
// Computes |v| * 2^16 / supply truncated, saturated to 2.0, sign restored,
// with a restoring divider that resolves two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_norm_div
    import svpwm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [NORM_STAGE:0]      i_en,
    input  wire logic signed [DATA_W-1:0] i_volt,
    input  wire logic [DATA_W-1:0]        i_supply,
    output logic signed [NORM_W-1:0]      o_norm
);

    localparam logic [QUO_W-1:0] SAT_Q = QUO_W'(Q_SAT);

    logic [DATA_W-1:0]       w_mag;
    logic                    w_ovf;

    logic [LOW_W-1:0]        r_low;
    logic [DATA_W-1:0]       r_rem [0:DIV_STEPS];
    logic [QUO_W-1:0]        r_q   [0:DIV_STEPS];
    logic [DATA_W-1:0]       r_div [0:DIV_STEPS];
    logic                    r_ovf [0:DIV_STEPS];
    logic                    r_neg [0:DIV_STEPS];
    logic [DATA_W-1:0]       n_rem [1:DIV_STEPS];
    logic [QUO_W-1:0]        n_q   [1:DIV_STEPS];
    logic signed [NORM_W-1:0] r_norm;
    logic signed [NORM_W-1:0] n_norm;
    logic [QUO_W-1:0]        w_tail;

    assign w_mag = i_volt[DATA_W-1] ? DATA_W'(-i_volt) : DATA_W'(i_volt);

    // The quotient cannot fit in QUO_W bits when |v| >= supply * 2^LOW_W;
    // that case saturates anyway.
    assign w_ovf = {{LOW_W{1'b0}}, w_mag} >= {i_supply, {LOW_W{1'b0}}};

    // Dividend bits not yet shifted in after the initial remainder.
    assign w_tail = {r_low, {(QUO_W-LOW_W){1'b0}}};

    always_comb begin
        logic [DATA_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [DATA_W:0]   trial;
        logic              ge;
        rem   = '0;
        quo   = '0;
        trial = '0;
        ge    = 1'b0;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            rem = r_rem[s-1];
            quo = r_q[s-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {rem, w_tail[QUO_W-1-((s-1)*DIV_BITS+b)]};
                ge    = trial >= {1'b0, r_div[s-1]};
                rem   = ge ? DATA_W'(trial - {1'b0, r_div[s-1]}) : trial[DATA_W-1:0];
                quo   = {quo[QUO_W-2:0], ge};
            end
            n_rem[s] = rem;
            n_q[s]   = quo;
        end
    end

    always_comb begin
        logic [QUO_W-1:0] mag_q;
        mag_q  = (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > SAT_Q)) ? SAT_Q : r_q[DIV_STEPS];
        n_norm = r_neg[DIV_STEPS] ? -$signed(NORM_W'(mag_q)) : $signed(NORM_W'(mag_q));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= {{LOW_W{1'b0}}, w_mag[DATA_W-1:LOW_W]};
            r_low    <= w_mag[LOW_W-1:0];
            r_q[0]   <= '0;
            r_div[0] <= i_supply;
            r_ovf[0] <= w_ovf;
            r_neg[0] <= i_volt[DATA_W-1];
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_div[s] <= r_div[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
        if (i_en[NORM_STAGE]) begin
            r_norm <= n_norm;
        end
    end

    assign o_norm = r_norm;

endmodule

`default_nettype wire

// ----- sv/svpwm_duty.sv -----
// ----------------------------------------------------------------------------
// Space vector PWM duty stages
// Scales beta by 1/sqrt3 and 2/sqrt3, picks the sector, forms the two active
// vector times and the three clamped phase duties over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_duty
    import svpwm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [DUTY_STAGES-1:0]   i_en,
    input  wire logic signed [NORM_W-1:0] i_alpha,
    input  wire logic signed [NORM_W-1:0] i_beta,
    input  wire logic                     i_fault,
    output logic [DUTY_W-1:0]             o_duty_u,
    output logic [DUTY_W-1:0]             o_duty_v,
    output logic [DUTY_W-1:0]             o_duty_w,
    output logic [SECTOR_W-1:0]           o_sector,
    output logic                          o_fault
);

    localparam int PROD_W = 38;
    localparam logic signed [17:0]       K1_S     = 18'(K_INV_SQRT3);
    localparam logic signed [17:0]       K2_S     = 18'(K_TWO_INV_SQRT3);
    localparam logic signed [PROD_W-1:0] ROUND_S  = PROD_W'(ROUND_HALF);
    localparam logic signed [T_W-1:0]    Q_ONE_S  = T_W'(Q_ONE);
    localparam logic signed [T_W-1:0]    DMAX_S   = T_W'(DUTY_MAX);

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [T_W-1:0] d);
        logic [DUTY_W-1:0] res;
        if (d < 0) begin
            res = '0;
        end else if (d > DMAX_S) begin
            res = DUTY_W'(DUTY_MAX);
        end else begin
            res = d[DUTY_W-1:0];
        end
        return res;
    endfunction

    // Stage one: constant multiplies with rounding to nearest, ties upward.
    logic signed [PROD_W-1:0] w_prod_1;
    logic signed [PROD_W-1:0] w_prod_2;
    logic signed [PROD_W-1:0] w_rnd_1;
    logic signed [PROD_W-1:0] w_rnd_2;
    logic signed [NORM_W-1:0] r_a;
    logic signed [T_W-1:0]    r_kb;
    logic signed [T_W-1:0]    r_k2b;
    logic                     r_b_neg;
    logic                     r_fault_1;

    assign w_prod_1 = i_beta * K1_S;
    assign w_prod_2 = i_beta * K2_S;
    assign w_rnd_1  = (w_prod_1 + ROUND_S) >>> Q_FRAC;
    assign w_rnd_2  = (w_prod_2 + ROUND_S) >>> Q_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a       <= i_alpha;
            r_kb      <= T_W'(w_rnd_1);
            r_k2b     <= T_W'(w_rnd_2);
            r_b_neg   <= i_beta[NORM_W-1];
            r_fault_1 <= i_fault;
        end
    end

    // Stage two: sector decision and the two active times, ordered so that
    // the second duty is first minus x and the third is second minus y.
    t_sector                 n_sector;
    logic signed [T_W-1:0]   n_x;
    logic signed [T_W-1:0]   n_y;
    t_sector                 r_sector_2;
    logic signed [T_W-1:0]   r_x_2;
    logic signed [T_W-1:0]   r_y_2;
    logic                    r_fault_2;

    always_comb begin
        logic signed [T_W-1:0] a;
        logic                  a_neg;
        a     = T_W'(r_a);
        a_neg = r_a[NORM_W-1];
        // A tie in the compare takes the else choice of each branch.
        if (!r_b_neg) begin
            if (!a_neg) begin
                n_sector = (r_kb > a) ? SECTOR_2 : SECTOR_1;
            end else begin
                n_sector = (-r_kb > a) ? SECTOR_3 : SECTOR_2;
            end
        end else begin
            if (!a_neg) begin
                n_sector = (-r_kb > a) ? SECTOR_5 : SECTOR_6;
            end else begin
                n_sector = (r_kb > a) ? SECTOR_4 : SECTOR_5;
            end
        end
        unique case (n_sector)
            SECTOR_1: begin
                n_x = a - r_kb;
                n_y = r_k2b;
            end
            SECTOR_2: begin
                n_x = r_kb - a;
                n_y = a + r_kb;
            end
            SECTOR_3: begin
                n_x = r_k2b;
                n_y = -a - r_kb;
            end
            SECTOR_4: begin
                n_x = -r_k2b;
                n_y = r_kb - a;
            end
            SECTOR_5: begin
                n_x = -a - r_kb;
                n_y = a - r_kb;
            end
            default: begin
                n_x = a + r_kb;
                n_y = -r_k2b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sector_2 <= n_sector;
            r_x_2      <= n_x;
            r_y_2      <= n_y;
            r_fault_2  <= r_fault_1;
        end
    end

    // Stage three: the leading duty, floor of half of (1 + t1 + t2).
    logic signed [T_W-1:0]   w_sum;
    logic signed [T_W-1:0]   r_h_3;
    logic signed [T_W-1:0]   r_x_3;
    logic signed [T_W-1:0]   r_y_3;
    t_sector                 r_sector_3;
    logic                    r_fault_3;

    assign w_sum = Q_ONE_S + r_x_2 + r_y_2;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_h_3      <= w_sum >>> 1;
            r_x_3      <= r_x_2;
            r_y_3      <= r_y_2;
            r_sector_3 <= r_sector_2;
            r_fault_3  <= r_fault_2;
        end
    end

    // Stage four: remaining duties, clamping and routing to the phases.
    logic signed [T_W-1:0]   w_d2;
    logic signed [T_W-1:0]   w_d3;
    logic [DUTY_W-1:0]       w_c1;
    logic [DUTY_W-1:0]       w_c2;
    logic [DUTY_W-1:0]       w_c3;
    logic [DUTY_W-1:0]       n_u;
    logic [DUTY_W-1:0]       n_v;
    logic [DUTY_W-1:0]       n_w;
    logic [DUTY_W-1:0]       r_u;
    logic [DUTY_W-1:0]       r_v;
    logic [DUTY_W-1:0]       r_w;
    t_sector                 r_sector_4;
    logic                    r_fault_4;

    assign w_d2 = r_h_3 - r_x_3;
    assign w_d3 = w_d2 - r_y_3;
    assign w_c1 = clamp_duty(r_h_3);
    assign w_c2 = clamp_duty(w_d2);
    assign w_c3 = clamp_duty(w_d3);

    always_comb begin
        unique case (r_sector_3)
            SECTOR_1: begin
                n_u = w_c1; n_v = w_c2; n_w = w_c3;
            end
            SECTOR_2: begin
                n_v = w_c1; n_u = w_c2; n_w = w_c3;
            end
            SECTOR_3: begin
                n_v = w_c1; n_w = w_c2; n_u = w_c3;
            end
            SECTOR_4: begin
                n_w = w_c1; n_v = w_c2; n_u = w_c3;
            end
            SECTOR_5: begin
                n_w = w_c1; n_u = w_c2; n_v = w_c3;
            end
            default: begin
                n_u = w_c1; n_w = w_c2; n_v = w_c3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_fault_4 <= r_fault_3;
            if (r_fault_3) begin
                r_u        <= '0;
                r_v        <= '0;
                r_w        <= '0;
                r_sector_4 <= SECTOR_1;
            end else begin
                r_u        <= n_u;
                r_v        <= n_v;
                r_w        <= n_w;
                r_sector_4 <= r_sector_3;
            end
        end
    end

    assign o_duty_u = r_u;
    assign o_duty_v = r_v;
    assign o_duty_w = r_w;
    assign o_sector = r_sector_4;
    assign o_fault  = r_fault_4;

endmodule

`default_nettype wire

// ----- sv/space_vector_pwm_duty.sv -----
// ----------------------------------------------------------------------------
// Space vector PWM duty generator
// Turns an alpha/beta voltage command and the supply voltage into three phase
// duties using sector-based space vector modulation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per update, tdata = {supply, beta, alpha}.
//   Master channel: one item per input, tdata = three Q0.16 duties, tuser =
//   sector number minus one and the supply fault flag.
//   From acceptance to the result on the master side an item passes through
//   one input stage, nine divider stages resolving two quotient bits each,
//   one saturation stage, then four duty stages (multiply, sector choice,
//   leading duty, clamp and routing).
//   Throughput is one item per cycle unless a stalled receiver has let the
//   pipeline fill; every stage carries its own valid bit. A zero supply gives
//   all duties zero, sector 0 and the fault flag set. Reset empties the
//   pipeline; no state carries over between items. When the receiver stalls,
//   results stay in place and the stages behind them keep filling bubbles, so
//   the slave side still accepts items until all 15 stages hold one.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_duty
    import svpwm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // [15:0] volt_alpha, [31:16] volt_beta,
                                          // [47:32] supply_volt
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [15:0] duty_u, [31:16] duty_v, [47:32] duty_w
    output logic [3:0]       o_m_tuser    // [2:0] sector_index, [3] supply_fault
);

    logic [PIPE_DEPTH-1:0]    w_en;
    logic signed [DATA_W-1:0] w_alpha;
    logic signed [DATA_W-1:0] w_beta;
    logic [DATA_W-1:0]        w_supply;
    logic signed [NORM_W-1:0] w_norm_a;
    logic signed [NORM_W-1:0] w_norm_b;
    logic                     r_fault [0:NORM_STAGE];
    logic [DUTY_W-1:0]        w_duty_u;
    logic [DUTY_W-1:0]        w_duty_v;
    logic [DUTY_W-1:0]        w_duty_w;
    logic [SECTOR_W-1:0]      w_sector;
    logic                     w_fault;

    assign w_alpha  = $signed(i_s_tdata[15:0]);
    assign w_beta   = $signed(i_s_tdata[31:16]);
    assign w_supply = i_s_tdata[47:32];

    svpwm_pipe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_en       (w_en)
    );

    svpwm_norm_div u_div_alpha (
        .i_clk    (i_clk),
        .i_en     (w_en[NORM_STAGE:0]),
        .i_volt   (w_alpha),
        .i_supply (w_supply),
        .o_norm   (w_norm_a)
    );

    svpwm_norm_div u_div_beta (
        .i_clk    (i_clk),
        .i_en     (w_en[NORM_STAGE:0]),
        .i_volt   (w_beta),
        .i_supply (w_supply),
        .o_norm   (w_norm_b)
    );

    // The supply fault rides alongside the divider stages.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_fault[0] <= (w_supply == '0);
        end
        for (int s = 1; s <= NORM_STAGE; s++) begin
            if (w_en[s]) begin
                r_fault[s] <= r_fault[s-1];
            end
        end
    end

    svpwm_duty u_duty (
        .i_clk    (i_clk),
        .i_en     (w_en[PIPE_DEPTH-1:NORM_STAGE+1]),
        .i_alpha  (w_norm_a),
        .i_beta   (w_norm_b),
        .i_fault  (r_fault[NORM_STAGE]),
        .o_duty_u (w_duty_u),
        .o_duty_v (w_duty_v),
        .o_duty_w (w_duty_w),
        .o_sector (w_sector),
        .o_fault  (w_fault)
    );

    assign o_m_tdata = {w_duty_w, w_duty_v, w_duty_u};
    assign o_m_tuser = {w_fault, w_sector};

    a_fault_zeroes_duties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[3]) |-> (o_m_tdata == '0 && o_m_tuser[2:0] == '0))
        else $error("supply fault item carries nonzero duties or sector");

    a_sector_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[2:0] <= 3'd5))
        else $error("sector index out of range");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- tb/sv/space_vector_pwm_duty_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Space vector PWM duty generator testbench
// Drives alpha/beta/supply items with random gaps and backpressure, predicts
// the three phase duties, sector and supply fault of every accepted item, and
// checks each result in order against the prediction.
// ----------------------------------------------------------------------------

module space_vector_pwm_duty_tb
    import svpwm_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty_u;
        logic [DUTY_W-1:0]   duty_v;
        logic [DUTY_W-1:0]   duty_w;
        logic [SECTOR_W-1:0] sector;
        logic                fault;
    } t_duty_result;

    class svpwm_scoreboard;
        t_duty_result expected_q[$];
        int           errors = 0;

        // Normalizes a command by the supply: Q2.16, saturated at magnitude 2.
        function longint scale_q16(logic signed [15:0] v, logic [15:0] sup);
            longint mag;
            longint q;
            mag = (v < 0) ? -longint'(v) : longint'(v);
            q = (mag * Q_ONE) / longint'(sup);
            if (q > Q_SAT) q = Q_SAT;
            return (v < 0) ? -q : q;
        endfunction

        function logic [DUTY_W-1:0] clip_duty(longint d);
            if (d < 0) return '0;
            if (d > DUTY_MAX) return DUTY_W'(DUTY_MAX);
            return d[DUTY_W-1:0];
        endfunction

        function t_duty_result predict_duties(logic signed [15:0] va,
                                              logic signed [15:0] vb,
                                              logic [15:0] sup);
            t_duty_result r;
            longint       a, b, kb, k2b, t1, t2, du, dv, dw;
            t_sector      sec;
            r = '0;
            if (sup == 0) begin
                r.fault = 1'b1;
                return r;
            end
            a = scale_q16(va, sup);
            b = scale_q16(vb, sup);
            // Arithmetic shifts give the floor of the rounded products.
            kb  = (b * K_INV_SQRT3 + ROUND_HALF) >>> Q_FRAC;
            k2b = (b * K_TWO_INV_SQRT3 + ROUND_HALF) >>> Q_FRAC;
            if (b >= 0) begin
                if (a >= 0) sec = (kb > a) ? SECTOR_2 : SECTOR_1;
                else        sec = (-kb > a) ? SECTOR_3 : SECTOR_2;
            end else begin
                if (a >= 0) sec = (-kb > a) ? SECTOR_5 : SECTOR_6;
                else        sec = (kb > a) ? SECTOR_4 : SECTOR_5;
            end
            case (sec)
                SECTOR_1: begin
                    t1 = a - kb;
                    t2 = k2b;
                    du = (Q_ONE + t1 + t2) >>> 1;
                    dv = du - t1;
                    dw = dv - t2;
                end
                SECTOR_2: begin
                    t1 = a + kb;
                    t2 = -a + kb;
                    dv = (Q_ONE + t1 + t2) >>> 1;
                    du = dv - t2;
                    dw = du - t1;
                end
                SECTOR_3: begin
                    t1 = k2b;
                    t2 = -a - kb;
                    dv = (Q_ONE + t1 + t2) >>> 1;
                    dw = dv - t1;
                    du = dw - t2;
                end
                SECTOR_4: begin
                    t1 = -a + kb;
                    t2 = -k2b;
                    dw = (Q_ONE + t1 + t2) >>> 1;
                    dv = dw - t2;
                    du = dv - t1;
                end
                SECTOR_5: begin
                    t1 = -a - kb;
                    t2 = a - kb;
                    dw = (Q_ONE + t1 + t2) >>> 1;
                    du = dw - t1;
                    dv = du - t2;
                end
                default: begin
                    t1 = -k2b;
                    t2 = a + kb;
                    du = (Q_ONE + t1 + t2) >>> 1;
                    dw = du - t2;
                    dv = dw - t1;
                end
            endcase
            r.duty_u = clip_duty(du);
            r.duty_v = clip_duty(dv);
            r.duty_w = clip_duty(dw);
            r.sector = sec;
            return r;
        endfunction

        function void note_command(logic [47:0] data);
            expected_q.push_back(predict_duties(data[15:0], data[31:16], data[47:32]));
        endfunction

        function void check_duties(t_duty_result got);
            t_duty_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: u=%0d v=%0d w=%0d sector=%0d fault=%0b",
                             got.duty_u, got.duty_v, got.duty_w, got.sector, got.fault);
                return;
            end
            want = expected_q.pop_front();
            if (got.duty_u !== want.duty_u || got.duty_v !== want.duty_v ||
                got.duty_w !== want.duty_w || got.sector !== want.sector ||
                got.fault !== want.fault) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected u=%0d v=%0d w=%0d sector=%0d fault=%0b",
                             want.duty_u, want.duty_v, want.duty_w, want.sector,
                             want.fault,
                             ", got u=%0d v=%0d w=%0d sector=%0d fault=%0b",
                             got.duty_u, got.duty_v, got.duty_w,
                             got.sector, got.fault);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [47:0] s_tdata   = '0;   // [15:0] volt_alpha, [31:16] volt_beta, [47:32] supply_volt
    logic        m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;        // [15:0] duty_u, [31:16] duty_v, [47:32] duty_w
    logic [3:0]  o_m_tuser;        // [2:0] sector_index, [3] supply_fault

    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;
    int          idle_cycles = 0;

    svpwm_scoreboard sb = new;

    space_vector_pwm_duty i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && o_s_tready) sb.note_command(s_tdata);
            if (o_m_tvalid && m_tready)
                sb.check_duties({o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                                 o_m_tuser[2:0], o_m_tuser[3]});
        end
    end

    // A run that stops moving items in either direction is hung.
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!o_m_tvalid);
        end
    end

    task automatic send_item(input logic [15:0] alpha, input logic [15:0] beta,
                             input logic [15:0] sup);
        int gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sup, beta, alpha};
        do @(posedge clk); while (!o_s_tready);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] signed_within(int unsigned lim);
        logic [15:0] mag;
        mag = 16'($urandom_range(0, lim));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic send_random_command();
        int          pick;
        int unsigned lim;
        logic [15:0] alpha, beta, sup;
        pick  = $urandom_range(0, 19);
        alpha = 16'($urandom);
        beta  = 16'($urandom);
        if (pick < 3) begin
            sup = 16'($urandom);
        end else if (pick == 3) begin
            sup = '0;
        end else if (pick == 4) begin
            sup = 16'($urandom_range(1, 255));
        end else begin
            // Commands mostly inside the hexagon or just past it.
            sup   = 16'($urandom_range(256, 65535));
            lim   = (sup > 32767) ? 32767 : sup;
            alpha = signed_within(lim);
            beta  = signed_within(lim);
        end
        send_item(alpha, beta, sup);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero supply, with and without commands.
        send_item(16'h7FFF, 16'h8000, 16'd0);
        send_item(16'd0, 16'd0, 16'd0);
        // Extremes and saturation.
        send_item(16'h7FFF, 16'd0, 16'hFFFF);
        send_item(16'h8000, 16'h8000, 16'd1);
        send_item(16'h7FFF, 16'h7FFF, 16'd1);
        send_item(16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(16'd0, 16'd0, 16'hFFFF);
        // One command in the middle of each sector.
        send_item(16'd433, 16'd250, 16'd1000);
        send_item(16'd0, 16'd500, 16'd1000);
        send_item(-16'd433, 16'd250, 16'd1000);
        send_item(-16'd433, -16'd250, 16'd1000);
        send_item(16'd0, -16'd500, 16'd1000);
        send_item(16'd433, -16'd250, 16'd1000);
        // With the supply at half scale these land exactly on a sector border,
        // where the strict comparison must take its false branch.
        send_item(16'd1, 16'd2, 16'd32768);
        send_item(-16'd1, 16'd2, 16'd32768);
        send_item(16'd1, -16'd2, 16'd32768);
        send_item(-16'd1, -16'd2, 16'd32768);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 0) || (phase == 3);
            recv_idle = (phase == 0) || (phase == 2);
            repeat (110) send_random_command();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.errors += sb.pending();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
